// ===== design/grr_pkg.sv =====
`default_nettype none

package grr_pkg;

	localparam int DEF_MAX_GROUP  = 16;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int CFG_W          = 5;
	localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd2;

	// per-cycle move of the cell row
	typedef enum logic [1:0] {
		CH_HOLD,
		CH_PUSH,   // new value into cell 0, all cells move up one
		CH_POP     // cell 0 leaves, all cells move down one
	} chain_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REV,
		ST_FWD
	} state_t;

	typedef struct packed {
		chain_op_t op;
		logic      load;     // load output register this cycle
		logic      sel_idx;  // 1: indexed cell, 0: cell 0
		logic      run_end;
		logic      seq_end;
	} ctl_t;

endpackage

`default_nettype wire

// ===== design/group_reverse_reorder_top.sv =====
`default_nettype none

// channel   dir   handshake            payload
// --------  ----  -------------------  ------------------------------------
// in        in    in_valid / in_stall  item_value, final_item
// out       out   out_valid/out_stall  out_value, run_end, sequence_end
// cfg       in    cfg_valid/cfg_ready  cfg_data (group_size)
//
// An item that closes a group (or ends the sequence) is followed by one
// emit per buffered item, drained from the cell row through the single
// output register. arst_n clears the sequencer, item count and
// group_size (to 2); cell contents are not reset. in_stall is high while
// a group is being emitted; out_stall freezes emission without losing
// anything.

module group_reverse_reorder_top #(
	parameter int MAX_GROUP  = grr_pkg::DEF_MAX_GROUP,
	parameter int DATA_WIDTH = grr_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input items
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] item_value,
	input  wire logic                         final_item,
	// results
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed      [DATA_WIDTH-1:0] out_value,
	output logic                              run_end,
	output logic                              sequence_end,
	// configuration
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [grr_pkg::CFG_W-1:0]    cfg_data
);
	import grr_pkg::*;

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [CFG_W-1:0]      group_size_q;
	ctl_t                  ctl;
	logic [IDX_W-1:0]      rd_idx;
	logic                  can_load;
	logic [DATA_WIDTH-1:0] cell_q [MAX_GROUP];
	logic [DATA_WIDTH-1:0] pick;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic                  run_end_q;
	logic                  seq_end_q;

	// config register, always ready; to be written only while the block is idle, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			group_size_q <= GROUP_SIZE_RST;
		else if (cfg_valid)
			group_size_q <= cfg_data;
	end

	// output register frees up when empty or when its result is taken
	assign can_load = !out_valid_q || !out_stall;

	grr_ctrl #(
		.MAX_GROUP (MAX_GROUP),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.final_item (final_item),
		.group_size (group_size_q),
		.can_load   (can_load),
		.in_stall   (in_stall),
		.ctl        (ctl),
		.rd_idx     (rd_idx)
	);

	// Cell row: newest item lives in cell 0. Push moves everything up one,
	// pop hands cell 0 out and moves everything down, so a popped group
	// comes out newest first. The top cell pops onto itself.
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] push_in;
		logic [DATA_WIDTH-1:0] pop_in;

		if (i == 0) begin : g_first
			assign push_in = item_value;
		end else begin : g_mid
			assign push_in = cell_q[i-1];
		end

		if (i == MAX_GROUP - 1) begin : g_last
			assign pop_in = cell_q[i];
		end else begin : g_up
			assign pop_in = cell_q[i+1];
		end

		grr_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.op      (ctl.op),
			.push_in (push_in),
			.pop_in  (pop_in),
			.q       (cell_q[i])
		);
	end

	// Incomplete tail of a sequence goes out oldest first: read the row
	// from the top of the filled part downward without moving it.
	assign pick = ctl.sel_idx ? cell_q[rd_idx] : cell_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (can_load)
			out_valid_q <= ctl.load;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			out_value_q <= pick;
			run_end_q   <= ctl.run_end;
			seq_end_q   <= ctl.seq_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign run_end      = run_end_q;
	assign sequence_end = seq_end_q;

endmodule

`default_nettype wire

// ===== design/grr_cell.sv =====
`default_nettype none

module grr_cell #(
	parameter int DATA_WIDTH = grr_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                    clk,
	input  wire grr_pkg::chain_op_t      op,
	input  wire logic [DATA_WIDTH-1:0]   push_in,
	input  wire logic [DATA_WIDTH-1:0]   pop_in,
	output logic      [DATA_WIDTH-1:0]   q
);
	import grr_pkg::*;

	logic [DATA_WIDTH-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CH_PUSH: val_q <= push_in;
			CH_POP:  val_q <= pop_in;
			default: val_q <= val_q;
		endcase
	end

	assign q = val_q;

endmodule

`default_nettype wire

// ===== design/grr_ctrl.sv =====
`default_nettype none

module grr_ctrl #(
	parameter int MAX_GROUP = grr_pkg::DEF_MAX_GROUP,
	parameter int CNT_W     = $clog2(MAX_GROUP + 1),
	parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      final_item,
	input  wire logic [grr_pkg::CFG_W-1:0] group_size,
	input  wire logic                      can_load,
	output logic                           in_stall,
	output grr_pkg::ctl_t                  ctl,
	output logic      [IDX_W-1:0]          rd_idx
);
	import grr_pkg::*;

	localparam int KW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic             last_q, last_d;

	logic [CNT_W-1:0] n;
	logic [KW-1:0]    k_eff;
	logic [KW-1:0]    gs_ext;

	assign n      = cnt_q + CNT_W'(1);
	assign gs_ext = KW'(group_size);

	always_comb begin
		priority if (gs_ext == '0)
			k_eff = KW'(1);
		else if (gs_ext > KW'(MAX_GROUP))
			k_eff = KW'(MAX_GROUP);
		else
			k_eff = gs_ext;
	end

	assign rd_idx = IDX_W'(rem_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		rem_d       = rem_q;
		last_d      = last_q;
		in_stall    = 1'b1;
		ctl.op      = CH_HOLD;
		ctl.load    = 1'b0;
		ctl.sel_idx = 1'b0;
		ctl.run_end = (rem_q == CNT_W'(1));
		ctl.seq_end = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.op = CH_PUSH;
					last_d = final_item;
					rem_d  = n;
					if (KW'(n) >= k_eff) begin
						state_d = ST_REV;
						cnt_d   = '0;
					end else if (final_item) begin
						state_d = ST_FWD;
						cnt_d   = '0;
					end else begin
						cnt_d = n;
					end
				end
			end
			ST_REV: begin
				ctl.seq_end = ctl.run_end && last_q;
				if (can_load) begin
					ctl.load = 1'b1;
					ctl.op   = CH_POP;
					rem_d    = rem_q - CNT_W'(1);
					if (ctl.run_end)
						state_d = ST_IDLE;
				end
			end
			ST_FWD: begin
				ctl.sel_idx = 1'b1;
				ctl.seq_end = ctl.run_end;
				if (can_load) begin
					ctl.load = 1'b1;
					rem_d    = rem_q - CNT_W'(1);
					if (ctl.run_end)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sim/grr_checker.sv =====
`default_nettype none

module grr_checker #(
	parameter int MAX_GROUP  = grr_pkg::DEF_MAX_GROUP,
	parameter int DATA_WIDTH = grr_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] item_value,
	input  wire logic                         final_item,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic signed [DATA_WIDTH-1:0] out_value,
	input  wire logic                         run_end,
	input  wire logic                         sequence_end,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [grr_pkg::CFG_W-1:0]    cfg_data,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         run_end;
		logic                         seq_end;
	} reorder_result_t;

	reorder_result_t              expected_q[$];
	logic signed [DATA_WIDTH-1:0] held_items[MAX_GROUP];
	int                           held_count;
	logic [grr_pkg::CFG_W-1:0]    group_size_q;
	int                           errors;

	// buffer one item; a full (or closed) group turns into expected results
	task automatic reorder_item(input logic signed [DATA_WIDTH-1:0] v, input logic last);
		int              k;
		int              n;
		reorder_result_t r;
		k = int'(group_size_q);
		if (k == 0)
			k = 1;
		if (k > MAX_GROUP)
			k = MAX_GROUP;
		if (held_count >= MAX_GROUP)
			held_count = MAX_GROUP - 1;
		held_items[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= k) begin
			for (int i = 0; i < n; i++) begin
				r.value   = held_items[n-1-i];
				r.run_end = (i == n - 1);
				r.seq_end = (i == n - 1) && last;
				expected_q.push_back(r);
			end
			held_count = 0;
		end else if (last) begin
			for (int i = 0; i < n; i++) begin
				r.value   = held_items[i];
				r.run_end = (i == n - 1);
				r.seq_end = (i == n - 1);
				expected_q.push_back(r);
			end
			held_count = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reorder_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			held_count   = 0;
			group_size_q = grr_pkg::GROUP_SIZE_RST;
			errors       = 0;
			fail_count  <= 0;
			pending     <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				group_size_q = cfg_data;
			if (in_valid && !in_stall)
				reorder_item(item_value, final_item);
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value=%0d run_end=%0b sequence_end=%0b",
						$time, out_value, run_end, sequence_end);
				end else begin
					want = expected_q.pop_front();
					if (out_value !== want.value) begin
						errors++;
						$display("%0t: out_value expected %0d actual %0d",
							$time, want.value, out_value);
					end
					if (run_end !== want.run_end) begin
						errors++;
						$display("%0t: run_end expected %0b actual %0b",
							$time, want.run_end, run_end);
					end
					if (sequence_end !== want.seq_end) begin
						errors++;
						$display("%0t: sequence_end expected %0b actual %0b",
							$time, want.seq_end, sequence_end);
					end
				end
			end
			fail_count <= errors;
			pending    <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW        = grr_pkg::DEF_DATA_WIDTH;
	localparam int MAX_GROUP = grr_pkg::DEF_MAX_GROUP;
	localparam int CW        = grr_pkg::CFG_W;

	// extremes of the item value
	localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

	// group size settings worth naming
	localparam logic [CW-1:0] SIZE_ZERO = '0;       // behaves as pass-through
	localparam logic [CW-1:0] SIZE_PASS = CW'(1);
	localparam logic [CW-1:0] SIZE_TWO  = CW'(2);
	localparam logic [CW-1:0] SIZE_FOUR = CW'(4);
	localparam logic [CW-1:0] SIZE_MAX  = CW'(MAX_GROUP);
	localparam logic [CW-1:0] SIZE_TOP  = '1;       // saturates to MAX_GROUP

	localparam int RANDOM_ITEMS  = 100;
	// a closing item is followed by up to MAX_GROUP emits; pad it
	localparam int SETTLE_CYCLES = 2 * MAX_GROUP + 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [DW-1:0] item_value;
	logic                 final_item;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [DW-1:0] out_value;
	logic                 run_end;
	logic                 sequence_end;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CW-1:0]        cfg_data;

	int   fail_count;
	int   pending;
	int   burst_left;
	int   cycle_count;
	logic hold_req;

	group_reverse_reorder_top #(
		.MAX_GROUP (MAX_GROUP),
		.DATA_WIDTH(DW)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.item_value  (item_value),
		.final_item  (final_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_value   (out_value),
		.run_end     (run_end),
		.sequence_end(sequence_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// prediction and comparison live in the checker; the top only drives
	grr_checker #(
		.MAX_GROUP (MAX_GROUP),
		.DATA_WIDTH(DW)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.item_value  (item_value),
		.final_item  (final_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_value   (out_value),
		.run_end     (run_end),
		.sequence_end(sequence_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends the run here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// value mix: extremes often, otherwise any bit pattern
	function automatic logic signed [DW-1:0] rand_value();
		logic signed [DW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = VAL_MIN;
			1: v = VAL_MAX;
			2: v = '0;
			3: v = '1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// small groups mostly; the odd zero, maximum or oversize setting
	function automatic logic [CW-1:0] pick_group_size();
		logic [CW-1:0] s;
		int            r;
		r = $urandom_range(0, 99);
		if (r < 70)
			s = CW'($urandom_range(1, 5));
		else if (r < 80)
			s = CW'($urandom_range(6, MAX_GROUP - 1));
		else if (r < 88)
			s = SIZE_MAX;
		else if (r < 94)
			s = SIZE_ZERO;
		else
			s = CW'($urandom_range(MAX_GROUP + 1, (1 << CW) - 1));
		return s;
	endfunction

	function automatic int size_in_effect(input logic [CW-1:0] s);
		int k;
		k = int'(s);
		if (k == 0)
			k = 1;
		if (k > MAX_GROUP)
			k = MAX_GROUP;
		return k;
	endfunction

	// Offer one item and hold it until the transaction completes. The sender
	// runs in bursts; valid only drops at the end of a burst, so back-to-back
	// items inside a burst never toggle it within one step.
	task automatic send_item(input logic signed [DW-1:0] v, input logic fin);
		item_value <= v;
		final_item <= fin;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
			                                         : $urandom_range(0, 8);
		end
	endtask

	// Register writes happen only with the block quiet: nothing expected and
	// enough extra cycles for an item that left no result to settle. Items
	// still buffered in a partial group stay there across the write.
	// It first waits for a clock edge so the checker's count covers the last accepted item.
	task automatic write_group_size(input logic [CW-1:0] size);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_data  <= size;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: stall pattern changes between runs of random length, from no
	// stall at all up to mostly stalled. Once asked, it holds off for a long stretch
	// so the cell row fills and the input side has to stall.
	initial begin
		int   mode;
		int   len;
		logic hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(5, 40);
				repeat (len) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 1) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin
		int            sent;
		int            budget;
		int            seq_len;
		int            keff;
		logic          noisy;
		logic          fin;
		logic          first_phase;
		logic [CW-1:0] size;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		item_value = '0;
		final_item = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		hold_req   = 1'b0;
		burst_left = 0;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset size of two: value extremes reversed in pairs, then a final
		// item that closes a full group (both end flags on its last result)
		send_item(VAL_MIN, 1'b0);
		send_item(VAL_MAX, 1'b0);
		send_item('0, 1'b0);
		send_item('1, 1'b1);
		// lone final item: incomplete group goes out in arrival order
		send_item(rand_value(), 1'b1);

		// size one passes straight through
		write_group_size(SIZE_PASS);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);

		// size zero behaves like one
		write_group_size(SIZE_ZERO);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);

		// oversize saturates; short sequence ends incomplete, oldest first
		write_group_size(SIZE_TOP);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);

		// size lowered while three items sit in the buffer: the next item
		// flushes all four reversed as one group
		write_group_size(SIZE_FOUR);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b0);
		write_group_size(SIZE_TWO);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);

		// --- random ---
		// Each phase writes a size, then streams mostly well-formed sequences
		// (final flag on the last item only) with some noisy ones. A phase
		// may stop mid-sequence, so the next write can land on a partial group.
		// The first phase uses the largest group and triggers the long hold-off.
		sent        = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			size = first_phase ? SIZE_MAX : pick_group_size();
			write_group_size(size);
			if (first_phase)
				hold_req <= 1'b1;
			first_phase = 1'b0;
			keff   = size_in_effect(size);
			budget = $urandom_range(keff, 2 * keff + 8);
			if (budget > RANDOM_ITEMS - sent)
				budget = RANDOM_ITEMS - sent;
			while (budget > 0) begin
				seq_len = $urandom_range(1, 2 * keff + 1);
				noisy   = ($urandom_range(0, 9) == 0);
				for (int j = 0; j < seq_len && budget > 0; j++) begin
					if (noisy)
						fin = ($urandom_range(0, 3) == 0);
					else
						fin = (j == seq_len - 1);
					send_item(rand_value(), fin);
					budget--;
					sent++;
				end
			end
		end

		// drain: everything expected must arrive, then a quiet tail to catch
		// anything extra the block might still emit
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== group_reverse_reorder_top.f =====
design/grr_pkg.sv
design/grr_cell.sv
design/grr_ctrl.sv
design/group_reverse_reorder_top.sv
sim/grr_checker.sv
sim/tb.sv
